// File: rtl/core/imu_fifo_packet_parser_core_assert.svh
// Assertion macros used by the parser's checker file.
`ifndef IMU_FIFO_PACKET_PARSER_CORE_ASSERT_SVH
`define IMU_FIFO_PACKET_PARSER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFPP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser port check failed");

// Consequent must hold in the cycle after the antecedent.
`define IFPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser port check failed");

`endif

// File: rtl/core/imu_fpp_pkg.sv
// Package with payload types and constants of the IMU FIFO packet parser.
package imu_fpp_pkg;

  localparam int PACKET_BYTES   = 20;
  localparam int STORE_BYTES    = PACKET_BYTES - 1;
  localparam int REC_DEPTH_DEF  = 4;

  localparam int HDR_MESSAGE_BIT = 7;
  localparam int HDR_HIRES_BIT   = 4;
  localparam int HDR_STAMP_BIT   = 3;

  localparam logic [7:0] SAMPLE_LIMIT_RESET = 8'd16;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_t;

  typedef struct packed {
    logic               record_kind;
    logic signed [19:0] accel_x;
    logic signed [19:0] accel_y;
    logic signed [19:0] accel_z;
    logic signed [19:0] gyro_x;
    logic signed [19:0] gyro_y;
    logic signed [19:0] gyro_z;
    logic signed [15:0] temperature;
    logic        [15:0] time_stamp;
    logic        [7:0]  sample_index;
    logic        [7:0]  sample_count;
    logic               final_record;
  } out_t;

  typedef struct packed {
    logic en0;
    logic en1;
  } fifo_wr_t;

endpackage

// File: rtl/core/imu_fifo_packet_parser_core.sv
// Top level of the IMU FIFO packet parser: byte chain, packet decode, record queue.
// Throughput: one byte transfer per cycle while the record queue has room for two records.
// A record is written into the record queue when the byte that causes it is accepted.
// The queue (REC_DEPTH records) sets the rate: a buffer end that yields two records
// needs two output transfers, so a stalled output holds off input once the queue nears full.
// Reset (rst, synchronous): position, sample count and queue empty; limit returns to 16.
module imu_fifo_packet_parser_core
  import imu_fpp_pkg::*;
#(
  parameter int REC_DEPTH = REC_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  localparam logic [4:0] POS_LAST = 5'(PACKET_BYTES - 1);

  // Control registers.
  logic [4:0] byte_position;
  logic [7:0] accepted_count;
  logic [7:0] sample_limit;

  // The shift chain: cell 0 holds the newest byte, so once the chain is full
  // cell STORE_BYTES-1 holds the header and cell 0 holds packet byte 18.
  logic [7:0] cell_q [STORE_BYTES];
  // The same bytes in packet order.
  logic [7:0] pkt_byte [STORE_BYTES];

  logic       accept;
  logic       pos_full;
  logic       is_last;
  logic       take_sample;
  logic [7:0] hdr;
  logic [7:0] b;
  logic       room2;
  fifo_wr_t   wr;
  out_t       sample_rec;
  out_t       summary_rec;
  out_t       wr_data0;

  // Packet byte k sits in cell STORE_BYTES-1-k.
  for (genvar k = 0; k < STORE_BYTES; k++) begin : g_pkt_byte
    assign pkt_byte[k] = cell_q[STORE_BYTES - 1 - k];
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = room2;
  assign pos_full = byte_position == POS_LAST;
  assign is_last  = accept && in_data.last_in_buffer;
  assign hdr      = pkt_byte[0];
  assign b        = in_data.data_byte;

  // A packet completes on the twentieth byte; it yields a sample only for a
  // high-resolution header without the message bit and while under the limit.
  assign take_sample = accept && pos_full && !hdr[HDR_MESSAGE_BIT] && hdr[HDR_HIRES_BIT]
                       && (accepted_count < sample_limit);

  // The chain shifts only on bytes that are stored; the final byte of a packet
  // is used straight from the input.
  generate
    for (genvar i = 0; i < STORE_BYTES; i++) begin : g_cell
      if (i == 0) begin : g_head
        imu_fpp_cell u_cell (
          .clk (clk),
          .en  (accept && !pos_full),
          .d   (b),
          .q   (cell_q[i])
        );
      end else begin : g_body
        imu_fpp_cell u_cell (
          .clk (clk),
          .en  (accept && !pos_full),
          .d   (cell_q[i-1]),
          .q   (cell_q[i])
        );
      end
    end
  endgenerate

  // Each 20-bit value is MSB, LSB and a nibble taken from the trailing bytes.
  always_comb begin
    sample_rec              = '0;
    sample_rec.record_kind  = KIND_SAMPLE;
    sample_rec.accel_x      = {pkt_byte[1],  pkt_byte[2],  pkt_byte[17][7:4]};
    sample_rec.accel_y      = {pkt_byte[3],  pkt_byte[4],  pkt_byte[18][7:4]};
    sample_rec.accel_z      = {pkt_byte[5],  pkt_byte[6],  b[7:4]};
    sample_rec.gyro_x       = {pkt_byte[7],  pkt_byte[8],  pkt_byte[17][3:0]};
    sample_rec.gyro_y       = {pkt_byte[9],  pkt_byte[10], pkt_byte[18][3:0]};
    sample_rec.gyro_z       = {pkt_byte[11], pkt_byte[12], b[3:0]};
    sample_rec.temperature  = {pkt_byte[13], pkt_byte[14]};
    sample_rec.time_stamp   = hdr[HDR_STAMP_BIT] ? {pkt_byte[15], pkt_byte[16]} : 16'd0;
    sample_rec.sample_index = accepted_count;
    sample_rec.sample_count = 8'd0;
    sample_rec.final_record = !in_data.last_in_buffer;
  end

  // The summary counts the sample that completes on the same byte, if any.
  always_comb begin
    summary_rec              = '0;
    summary_rec.record_kind  = KIND_SUMMARY;
    summary_rec.sample_count = accepted_count + 8'(take_sample);
    summary_rec.final_record = 1'b1;
  end

  // The sample always goes first; the summary fills the second slot when
  // both occur on one byte.
  assign wr.en0   = take_sample || is_last;
  assign wr.en1   = take_sample && is_last;
  assign wr_data0 = take_sample ? sample_rec : summary_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      accepted_count <= '0;
      sample_limit   <= SAMPLE_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        sample_limit <= cfg_data;
      end
      if (accept) begin
        if (in_data.last_in_buffer || pos_full) begin
          byte_position <= '0;
        end else begin
          byte_position <= byte_position + 5'd1;
        end
        if (in_data.last_in_buffer) begin
          accepted_count <= '0;
        end else if (take_sample) begin
          accepted_count <= accepted_count + 8'd1;
        end
      end
    end
  end

  imu_fpp_rec_fifo #(
    .DEPTH (REC_DEPTH)
  ) u_rec_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_data0  (wr_data0),
    .wr_data1  (summary_rec),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/imu_fpp_cell.sv
// One byte cell of the packet shift chain.
module imu_fpp_cell (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

// File: rtl/core/imu_fpp_rec_fifo.sv
// Small record queue that takes up to two records per cycle and gives one per cycle while out_ready is high.
module imu_fpp_rec_fifo
  import imu_fpp_pkg::*;
#(
  parameter int DEPTH = REC_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  fifo_wr_t wr,
  input  out_t     wr_data0,
  input  out_t     wr_data1,
  output logic     room2,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   wr_ptr_p1;
  logic [AW-1:0]   wr_ptr_p2;
  logic            pop;
  logic [CW-1:0]   push_n;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr);
  assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
  assign pop       = out_valid && out_ready;
  assign push_n    = CW'(wr.en0) + CW'(wr.en1);
  assign room2     = cnt <= CW'(DEPTH - 2);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.en0) begin
      mem[wr_ptr] <= wr_data0;
    end
    if (wr.en1) begin
      mem[wr_ptr_p1] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr.en0 && wr.en1) begin
        wr_ptr <= wr_ptr_p2;
      end else if (wr.en0) begin
        wr_ptr <= wr_ptr_p1;
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      cnt <= cnt + push_n - CW'(pop);
    end
  end

endmodule

// File: rtl/core/imu_fpp_checker.sv
// Port-level checks of the IMU FIFO packet parser and their binding.
`include "imu_fifo_packet_parser_core_assert.svh"

module imu_fpp_checker
  import imu_fpp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input out_t       out_data
);

  `IFPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IFPP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `IFPP_ASSERT_SAME(a_summary_final, out_valid && out_data.record_kind == KIND_SUMMARY,
                    out_data.final_record)
  `IFPP_ASSERT_SAME(a_summary_clear, out_valid && out_data.record_kind == KIND_SUMMARY,
                    out_data.accel_x == '0 && out_data.sample_index == '0)

endmodule

bind imu_fifo_packet_parser_core imu_fpp_checker u_imu_fpp_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the IMU FIFO packet parser core.
`timescale 1ns / 1ps

module tb;
  import imu_fpp_pkg::*;

  // A cycle count with no transfer on either channel that can only mean a hang.
  // The longest correct quiet spell is an input gap, an output stall and a short pause
  // before a limit write, so this is far beyond it.
  localparam int HANG_CYCLES = 1000;
  // Cycles to let pass after the last byte before checking that every expected record
  // has come out. The block queues a record when its byte is accepted.
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;

  // Test control: random idling on the input and output side.
  logic       in_gaps = 1'b1;
  logic       out_stalls = 1'b1;
  int         stall_left = 0;
  int         bytes_sent = 0;
  int         errors = 0;
  int         quiet_cycles = 0;

  // Shadow copy of the parser state, advanced on every accepted byte.
  logic [4:0] pkt_pos = '0;
  logic [7:0] pkt_bytes [STORE_BYTES];
  logic [7:0] samples_taken = '0;
  logic [7:0] limit_now = SAMPLE_LIMIT_RESET;
  out_t       records_due [$];

  imu_fifo_packet_parser_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (pkt_bytes[i]) pkt_bytes[i] = '0;
  end

  // Work out the records that one accepted byte causes. A packet is judged when its
  // twentieth byte arrives; that byte itself is never stored but supplies the z nibbles.
  task automatic parse_byte(input in_t item);
    out_t       rec;
    logic [7:0] hdr;
    logic [7:0] b;
    hdr = pkt_bytes[0];
    b = item.data_byte;
    if (pkt_pos < STORE_BYTES) begin
      pkt_bytes[pkt_pos] = b;
      pkt_pos++;
    end else begin
      pkt_pos = '0;
      if (!hdr[HDR_MESSAGE_BIT] && hdr[HDR_HIRES_BIT] && samples_taken < limit_now) begin
        rec = '0;
        rec.record_kind = KIND_SAMPLE;
        rec.accel_x = {pkt_bytes[1], pkt_bytes[2], pkt_bytes[17][7:4]};
        rec.accel_y = {pkt_bytes[3], pkt_bytes[4], pkt_bytes[18][7:4]};
        rec.accel_z = {pkt_bytes[5], pkt_bytes[6], b[7:4]};
        rec.gyro_x = {pkt_bytes[7], pkt_bytes[8], pkt_bytes[17][3:0]};
        rec.gyro_y = {pkt_bytes[9], pkt_bytes[10], pkt_bytes[18][3:0]};
        rec.gyro_z = {pkt_bytes[11], pkt_bytes[12], b[3:0]};
        rec.temperature = {pkt_bytes[13], pkt_bytes[14]};
        rec.time_stamp = hdr[HDR_STAMP_BIT] ? {pkt_bytes[15], pkt_bytes[16]} : 16'h0000;
        rec.sample_index = samples_taken;
        rec.final_record = !item.last_in_buffer;
        records_due.push_back(rec);
        samples_taken++;
      end
    end
    // The buffer end always adds a summary after any sample, and starts a fresh packet.
    if (item.last_in_buffer) begin
      rec = '0;
      rec.record_kind = KIND_SUMMARY;
      rec.sample_count = samples_taken;
      rec.final_record = 1'b1;
      records_due.push_back(rec);
      samples_taken = '0;
      pkt_pos = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Input monitor. Values read here are those that held at the edge, since every
  // driver in this file updates through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) parse_byte(in_data);
  end

  // Output monitor: each record transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (records_due.size() == 0) begin
        $error("record with no expectation waiting: kind %0b", out_data.record_kind);
        errors++;
      end else begin
        want = records_due.pop_front();
        check_field("record_kind", want.record_kind, out_data.record_kind);
        check_field("accel_x", want.accel_x, out_data.accel_x);
        check_field("accel_y", want.accel_y, out_data.accel_y);
        check_field("accel_z", want.accel_z, out_data.accel_z);
        check_field("gyro_x", want.gyro_x, out_data.gyro_x);
        check_field("gyro_y", want.gyro_y, out_data.gyro_y);
        check_field("gyro_z", want.gyro_z, out_data.gyro_z);
        check_field("temperature", want.temperature, out_data.temperature);
        check_field("time_stamp", want.time_stamp, out_data.time_stamp);
        check_field("sample_index", want.sample_index, out_data.sample_index);
        check_field("sample_count", want.sample_count, out_data.sample_count);
        check_field("final_record", want.final_record, out_data.final_record);
      end
    end
  end

  // Output ready: random stall bursts, started only while stalls are enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_stalls && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hang detector: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_CYCLES) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one byte and return once it is taken. Valid is left high, so back-to-back
  // bytes keep it up; a gap lowers it first and waits a random burst.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned hold;
    if (in_gaps && $urandom_range(0, 7) == 0) begin
      hold = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: value, last_in_buffer: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Stop offering input, give the last byte's records time to be predicted, then wait
  // until every expected record has come out.
  task automatic drain;
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_sample_limit(input logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    limit_now = value;
    cfg_we <= 1'b0;
  endtask

  // Payload bytes lean toward the sign boundaries of the assembled values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // Headers are mostly high-resolution packets, with the message bit, plain
  // packets and fully random headers mixed in as noise.
  function automatic logic [7:0] pick_header();
    logic [7:0] h;
    h = 8'($urandom);
    case ($urandom_range(0, 9))
      0: return h;
      1: begin
        h[HDR_MESSAGE_BIT] = 1'b1;
        return h;
      end
      2: begin
        h[HDR_MESSAGE_BIT] = 1'b0;
        h[HDR_HIRES_BIT] = 1'b0;
        return h;
      end
      default: begin
        h[HDR_MESSAGE_BIT] = 1'b0;
        h[HDR_HIRES_BIT] = 1'b1;
        return h;
      end
    endcase
  endfunction

  // One buffer of whole packets and an optional partial tail. When change_at is not
  // negative, the limit is rewritten just before that byte, inside the buffer.
  task automatic send_buffer(input int packets, input int tail, input int change_at,
                             input logic [7:0] new_limit);
    int total;
    total = packets * PACKET_BYTES + tail;
    if (total == 0) total = 1;
    for (int idx = 0; idx < total; idx++) begin
      if (idx == change_at) set_sample_limit(new_limit);
      send_byte((idx % PACKET_BYTES == 0) ? pick_header() : pick_byte(), idx == total - 1);
    end
  endtask

  function automatic int pick_tail();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, PACKET_BYTES - 1) : 0;
  endfunction

  // A packet with extreme values that completes on the buffer's last byte, so the
  // sample and the summary arrive on one transfer; then a partial buffer that is
  // dropped, and a buffer of a single byte.
  task automatic test_directed_packet;
    logic [7:0] pkt [PACKET_BYTES];
    pkt = '{8'h18, 8'h80, 8'h00, 8'h7f, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff,
            8'h80, 8'h01, 8'h7f, 8'hfe, 8'h80, 8'h00, 8'hff, 8'hff,
            8'h0f, 8'hf0, 8'ha5};
    for (int i = 0; i < PACKET_BYTES; i++) send_byte(pkt[i], i == PACKET_BYTES - 1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Walk the limit through its extremes and a few small values that bite early.
  task automatic test_limit_sweep;
    logic [7:0] limits [6];
    limits = '{8'd0, 8'd255, 8'd1, 8'd2, SAMPLE_LIMIT_RESET, 8'($urandom)};
    foreach (limits[i]) begin
      set_sample_limit(limits[i]);
      send_buffer($urandom_range(1, 3), pick_tail(), -1, '0);
    end
  endtask

  // The limit moves partway through a buffer; the count carries over.
  task automatic test_limit_mid_buffer;
    int packets;
    repeat (3) begin
      set_sample_limit(8'($urandom_range(0, 3)));
      packets = $urandom_range(2, 4);
      send_buffer(packets, 0, $urandom_range(1, packets * PACKET_BYTES - 1),
                  8'($urandom_range(0, 4)));
    end
  endtask

  // Random buffers with occasional limit changes, and idling switched on and off
  // per buffer so that long stretches run at full rate.
  task automatic test_random_stream;
    int stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: set_sample_limit(8'd0);
          1: set_sample_limit(8'd255);
          default: set_sample_limit(8'($urandom_range(1, 6)));
        endcase
      end
      in_gaps = $urandom_range(0, 3) != 0;
      out_stalls = $urandom_range(0, 3) != 0;
      send_buffer($urandom_range(0, 6), pick_tail(), -1, '0);
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_quiet_tail;
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    set_sample_limit(SAMPLE_LIMIT_RESET);
    repeat (3) send_buffer($urandom_range(1, 2), pick_tail(), -1, '0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_packet();
    test_limit_sweep();
    test_limit_mid_buffer();
    test_random_stream();
    test_quiet_tail();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
